[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

[rtl/core/lmts_pkg.sv]
package lmts_pkg;

  // LFSR register width; tap WIDTH is fixed and maps to register bit 0.
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(WIDTH);
  localparam int TAP_W = 5;
  localparam int CNT_W = 32;

  localparam logic [CNT_W:0] PERIOD_FULL = (CNT_W + 1)'((64'd1 << WIDTH) - 64'd1);

  localparam logic [TAP_W-1:0] TAP_B_START = TAP_W'(WIDTH - 1);
  localparam logic [TAP_W-1:0] TAP_C_START = TAP_W'(WIDTH - 2);
  localparam logic [TAP_W-1:0] TAP_D_START = TAP_W'(WIDTH - 3);

  localparam logic [TAP_W-1:0] TAP_B_LAST = TAP_W'(3);
  localparam logic [TAP_W-1:0] TAP_C_LAST = TAP_W'(2);
  localparam logic [TAP_W-1:0] TAP_D_LAST = TAP_W'(1);

  // Register selector, taken from paddr bit 2 (word index).
  localparam logic REG_INITIAL_STATE = 1'b0;

  typedef struct packed {
    logic [TAP_W-1:0] b;
    logic [TAP_W-1:0] c;
    logic [TAP_W-1:0] d;
  } taps_t;

  typedef struct packed {
    logic [WIDTH-1:0] shift_reg;
    logic [CNT_W-1:0] step_count;
    logic             hit;
    logic             maximal;
    taps_t            taps;
    logic             done;
  } step_t;

  typedef struct packed {
    taps_t            taps;
    logic [CNT_W-1:0] period;
    logic             maximal;
    logic             search_done;
  } result_t;

endpackage

[rtl/core/lmts_step.sv]
module lmts_step
  import lmts_pkg::*;
(
  input  logic [WIDTH-1:0] shift_reg,
  input  logic [CNT_W-1:0] step_count,
  input  logic [WIDTH-1:0] seed,
  input  taps_t            taps,
  output step_t            nxt
);

  function automatic logic read_tap(input logic [WIDTH-1:0] v, input logic [TAP_W-1:0] tap);
    logic [IDX_W:0] idx;
    idx = (IDX_W + 1)'(WIDTH) - (IDX_W + 1)'(tap);
    return v[idx[IDX_W-1:0]];
  endfunction

  logic fb;

  always_comb begin
    fb = shift_reg[0] ^ read_tap(shift_reg, taps.b) ^ read_tap(shift_reg, taps.c)
         ^ read_tap(shift_reg, taps.d);
    nxt.shift_reg  = {fb, shift_reg[WIDTH-1:1]};
    nxt.step_count = (step_count == '1) ? step_count : step_count + CNT_W'(1);
    nxt.hit        = (nxt.shift_reg == seed);
    nxt.maximal    = ({1'b0, nxt.step_count} >= PERIOD_FULL);

    // Advance to the next strictly decreasing tap triple.
    nxt.taps = taps;
    nxt.done = 1'b0;
    priority if (taps.d > TAP_D_LAST) begin
      nxt.taps.d = taps.d - TAP_W'(1);
    end else if (taps.c > TAP_C_LAST) begin
      nxt.taps.c = taps.c - TAP_W'(1);
      nxt.taps.d = taps.c - TAP_W'(2);
    end else if (taps.b > TAP_B_LAST) begin
      nxt.taps.b = taps.b - TAP_W'(1);
      nxt.taps.c = taps.b - TAP_W'(2);
      nxt.taps.d = taps.b - TAP_W'(3);
    end else begin
      nxt.done = 1'b1;
    end
  end

endmodule

[rtl/core/lfsr_maximal_tap_search.sv]
// A result is registered on result_valid by the run transaction that closes a period, via skid on a stall.
// Throughput: one run transaction per cycle while the skid stage is empty; the shift, saturating
// count and seed compare are combinational, and a skid stage keeps input open while a result waits.
// Reset (rst, synchronous, active high): seed = 1, register = seed, count = 0,
// taps 31/30/29, search not done, output and skid stages empty.
`include "assert_macros.svh"

module lfsr_maximal_tap_search
  import lmts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // run transactions
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             run,
  // result transactions
  output logic             result_valid,
  input  logic             result_ready,
  output logic [TAP_W-1:0] tap_b,
  output logic [TAP_W-1:0] tap_c,
  output logic [TAP_W-1:0] tap_d,
  output logic [CNT_W-1:0] period,
  output logic             maximal,
  output logic             search_done
);

  // Search state
  logic [31:0]      initial_state;
  logic [WIDTH-1:0] shift_reg;
  logic [CNT_W-1:0] step_count;
  taps_t            taps;
  logic             all_done;

  // Output register and skid stage
  result_t          out_data;
  result_t          skid_data;
  logic             skid_valid;

  step_t            nxt;
  result_t          new_result;
  logic             cfg_write;
  logic             accept;
  logic             stepping;
  logic             produce;
  logic             out_free;

  lmts_step u_step (
    .shift_reg (shift_reg),
    .step_count(step_count),
    .seed      (initial_state[WIDTH-1:0]),
    .taps      (taps),
    .nxt       (nxt)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_INITIAL_STATE);

  always_comb begin
    prdata = (paddr[2] == REG_INITIAL_STATE) ? initial_state : '0;
  end

  // Accept input whenever the skid stage is empty; a result then always has a slot.
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign stepping   = accept && run && !all_done;
  assign produce    = stepping && nxt.hit;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    new_result.taps        = taps;
    new_result.period      = nxt.step_count;
    new_result.maximal     = nxt.maximal;
    new_result.search_done = nxt.done;
  end

  // Search state: a seed write reloads the register and restarts the current taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state <= 32'd1;
      shift_reg     <= WIDTH'(1);
      step_count    <= '0;
      taps.b        <= TAP_B_START;
      taps.c        <= TAP_C_START;
      taps.d        <= TAP_D_START;
      all_done      <= 1'b0;
    end else if (cfg_write) begin
      initial_state <= pwdata;
      shift_reg     <= pwdata[WIDTH-1:0];
      step_count    <= '0;
    end else if (stepping) begin
      if (nxt.hit) begin
        // Period closed: reload the seed, clear the count, move to the next taps.
        shift_reg  <= initial_state[WIDTH-1:0];
        step_count <= '0;
        taps       <= nxt.taps;
        all_done   <= nxt.done;
      end else begin
        shift_reg  <= nxt.shift_reg;
        step_count <= nxt.step_count;
      end
    end
  end

  // Output side: drain skid first to keep order, park a new result in skid on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (produce) begin
        out_data <= new_result;
      end
    end else if (produce) begin
      skid_data <= new_result;
    end
  end

  assign tap_b       = out_data.taps.b;
  assign tap_c       = out_data.taps.c;
  assign tap_d       = out_data.taps.d;
  assign period      = out_data.period;
  assign maximal     = out_data.maximal;
  assign search_done = out_data.search_done;

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || result_valid, "skid holds a result while output stage is empty")
  `ASSERT_ALWAYS(a_tap_order, clk, rst, (taps.b > taps.c) && (taps.c > taps.d) && (taps.d != '0), "taps out of strictly decreasing order")
  `ASSERT_NEXT(a_done_sticky, clk, rst, all_done, all_done, "search finished flag dropped")
  `ASSERT_ALWAYS(a_done_report, clk, rst, !(result_valid && search_done) || all_done, "final report without finished search")

endmodule
